@@ hdl/tcts_pkg.sv @@
// tcts_pkg: shared types, constants and opcodes for the three channel tone sequencer
// no dependencies
`default_nettype none
package tcts_pkg;
    localparam int NOTES_PER_CHANNEL = 256;
    localparam int NCH               = 3;
    localparam int TONE_CLOCK_HZ     = 2000000;
    localparam int NOTE_IDX_W        = 8;
    localparam int TABLE_DEPTH       = NCH * NOTES_PER_CHANNEL;
    localparam int TABLE_AW          = $clog2(TABLE_DEPTH);
    localparam int PTR_W             = 9;
    localparam int CNT_W             = 17;
    localparam int QUOT_W            = 22;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [15:0] GAP_RESET = 16'd20;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    localparam logic [1:0] CH_RIGHT  = 2'd0;
    localparam logic [1:0] CH_CENTER = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  channel;
        logic [7:0]  note_index;
        logic [15:0] note_delay;
        logic [15:0] note_freq;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  out_channel;
        logic        tone_on;
        logic [15:0] period_ticks;
        logic [14:0] compare_ticks;
        logic        last;
        logic        all_idle;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START_RD,
        ST_START_WR,
        ST_CH,
        ST_FETCH,
        ST_DIV,
        ST_EMIT,
        ST_WAIT_OUT
    } t_state;

    // divider request / status between top and divider
    typedef struct packed {
        logic        start;
        logic [15:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [15:0] period;
    } t_div_rsp;
endpackage
`default_nettype wire

@@ hdl/tcts_ram.sv @@
// tcts_ram: generic single port synchronous ram with registered read
// no dependencies
`default_nettype none
module tcts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 768
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // read first port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

@@ hdl/tcts_div.sv @@
// tcts_div: restoring divider, one quotient bit per cycle, saturated period
// depends on tcts_pkg
`default_nettype none
module tcts_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tcts_pkg::t_div_req i_req,
    output tcts_pkg::t_div_rsp     o_rsp
);
    localparam int QW = tcts_pkg::QUOT_W;
    localparam logic [QW-1:0] DIVIDEND = QW'(tcts_pkg::TONE_CLOCK_HZ);
    localparam int SW = $clog2(QW + 1);

    logic [QW-1:0] r_quot, n_quot;
    logic [16:0]   r_rem, n_rem;
    logic [15:0]   r_dvs;
    logic [SW-1:0] r_step, n_step;
    logic          r_busy, r_done;
    logic [16:0]   rem_sh;

    // one shift and subtract per cycle
    always_comb begin
        rem_sh = {r_rem[15:0], DIVIDEND[r_step - SW'(1)]};
        n_rem  = rem_sh;
        n_quot = {r_quot[QW-2:0], 1'b0};
        if (rem_sh >= {1'b0, r_dvs}) begin
            n_rem     = rem_sh - {1'b0, r_dvs};
            n_quot[0] = 1'b1;
        end
        n_step = r_step - SW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= SW'(QW);
                r_rem  <= '0;
                r_quot <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_quot <= n_quot;
                r_step <= n_step;
                if (n_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // saturate to 16 bits
    assign o_rsp.busy   = r_busy;
    assign o_rsp.done   = r_done;
    assign o_rsp.period = (r_quot[QW-1:16] != '0) ? 16'hFFFF : r_quot[15:0];
endmodule
`default_nettype wire

@@ hdl/three_channel_tone_sequencer.sv @@
// three_channel_tone_sequencer: top level, sequencer fsm, apb register, channel state
// depends on tcts_pkg, tcts_ram, tcts_div
//
// Plays three note channels (0 right, 1 left, 2 center) from one note table ram of
// 3 x 256 words (delay in 31:16, freq in 15:0). Items are taken one at a time. A load
// writes one table word for channels 0 to 2, a start reads entry 0 of each channel in
// turn, and a stop or a tick visits each channel in turn. A tick reads the ram for a
// channel whose note is due and, for a sounding note, runs a 22 step bit-serial divide
// of 2000000 by the frequency; a rest note needs no divide. Output stalls hold items back.
// Each tone generator update is one output transfer; last marks the final one of an
// item. silence_gap_ms sits at apb address 0 (reset 20).
`default_nettype none
module three_channel_tone_sequencer (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire tcts_pkg::t_in_item    i_item,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output tcts_pkg::t_out_item        o_item,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic                  paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    localparam int AW = tcts_pkg::TABLE_AW;
    localparam int PW = tcts_pkg::PTR_W;
    localparam int CW = tcts_pkg::CNT_W;
    localparam int NPC = tcts_pkg::NOTES_PER_CHANNEL;
    localparam int NOTE_BITS = $clog2(NPC);

    // config register
    logic [15:0] r_gap;
    assign pready = 1'b1;
    assign prdata = {16'd0, r_gap};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= tcts_pkg::GAP_RESET;
        end else if (psel && penable && pwrite && paddr == 1'b0) begin
            r_gap <= pwdata[15:0];
        end
    end

    // per channel state
    logic [2:0]    r_play;
    logic [PW-1:0] r_ptr [3];
    logic [PW-1:0] r_len [3];
    logic [CW-1:0] r_cnt [3];
    logic [15:0]   r_dly [3];

    tcts_pkg::t_state r_state, n_state;
    tcts_pkg::t_in_item r_in;
    logic [1:0] r_ch;
    logic       r_fidle;   // no channel playing once this item is done
    tcts_pkg::t_out_item r_out;
    logic       r_oval;
    logic       r_pend;    // held result awaiting last decision
    tcts_pkg::t_out_item r_hold;

    // fetched frequency is held here during the divide
    logic [15:0] r_dly_f;

    // ram
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0]   ram_rdata;
    tcts_ram #(.WIDTH(32), .DEPTH(tcts_pkg::TABLE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata({i_item.note_delay, i_item.note_freq}),
        .o_rdata(ram_rdata)
    );

    tcts_pkg::t_div_req div_req;
    tcts_pkg::t_div_rsp div_rsp;
    tcts_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    function automatic logic [AW-1:0] tab_addr(input logic [1:0] ch, input logic [PW-1:0] p);
        logic [AW-1:0] a;
        a = AW'(ch) * AW'(NPC) + AW'(p[NOTE_BITS-1:0]);
        return a;
    endfunction

    logic accept;
    assign accept = i_valid && o_ready;
    assign o_ready = (r_state == tcts_pkg::ST_IDLE) && !r_pend && !r_oval;

    // channels still playing after a tick: a playing channel stops only when its pointer reaches its length
    logic [2:0] run_next;
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            run_next[c] = r_play[c] && (r_ptr[c] < r_len[c]);
        end
    end

    // channel decision for the current channel
    logic [CW-1:0] cur_cnt;
    logic [15:0]   cur_dly;
    logic          gap_hit;
    assign cur_cnt = r_cnt[r_ch];
    assign cur_dly = r_dly[r_ch];
    assign gap_hit = (r_gap != 16'd0) && (r_gap <= cur_dly)
                     && (cur_cnt == CW'(cur_dly - r_gap));

    // new result staging: pushes a result into the hold slot
    logic          push;
    tcts_pkg::t_out_item push_item;
    logic          fin;       // item done this cycle
    logic          out_free;
    assign out_free = !r_oval || i_ready;

    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_addr  = tab_addr(r_ch, r_ptr[r_ch]);
        div_req   = '0;
        push      = 1'b0;
        push_item = '0;
        fin       = 1'b0;
        push_item.out_channel = r_ch;
        unique case (r_state)
            tcts_pkg::ST_IDLE: begin
                ram_addr = tab_addr(i_item.channel, PW'(i_item.note_index));
                if (accept) begin
                    unique case (i_item.op)
                        tcts_pkg::OP_LOAD: ram_we = (i_item.channel <= tcts_pkg::CH_CENTER);
                        tcts_pkg::OP_START: n_state = tcts_pkg::ST_START_RD;
                        default: n_state = tcts_pkg::ST_CH;
                    endcase
                end
            end
            tcts_pkg::ST_START_RD: begin
                ram_addr = tab_addr(r_ch, '0);
                n_state  = tcts_pkg::ST_START_WR;
            end
            tcts_pkg::ST_START_WR: begin
                n_state = (r_ch == tcts_pkg::CH_CENTER) ? tcts_pkg::ST_IDLE
                                                        : tcts_pkg::ST_START_RD;
            end
            tcts_pkg::ST_CH: begin
                if (!r_pend || out_free) begin
                    if (r_in.op == tcts_pkg::OP_STOP) begin
                        push = 1'b1;
                    end else if (r_play[r_ch]) begin
                        if (r_ptr[r_ch] >= r_len[r_ch]) push = 1'b1;
                        else if (cur_cnt == CW'(1)) n_state = tcts_pkg::ST_FETCH;
                        else if (gap_hit) push = 1'b1;
                    end
                    if (n_state == tcts_pkg::ST_CH && r_ch == tcts_pkg::CH_CENTER) begin
                        fin = 1'b1;
                        n_state = tcts_pkg::ST_WAIT_OUT;
                    end
                end
            end
            tcts_pkg::ST_FETCH: begin
                if (ram_rdata[15:0] == 16'd0) begin
                    n_state = tcts_pkg::ST_EMIT;
                end else begin
                    div_req.start   = 1'b1;
                    div_req.divisor = ram_rdata[15:0];
                    n_state = tcts_pkg::ST_DIV;
                end
            end
            tcts_pkg::ST_DIV: begin
                if (div_rsp.done) n_state = tcts_pkg::ST_EMIT;
            end
            tcts_pkg::ST_EMIT: begin
                if (!r_pend || out_free) begin
                    push = 1'b1;
                    push_item.tone_on = r_dly_f != 16'd0;
                    if (r_dly_f != 16'd0) begin
                        push_item.period_ticks  = div_rsp.period;
                        push_item.compare_ticks = div_rsp.period[15:1];
                    end
                    if (r_ch == tcts_pkg::CH_CENTER) begin
                        fin = 1'b1;
                        n_state = tcts_pkg::ST_WAIT_OUT;
                    end else begin
                        n_state = tcts_pkg::ST_CH;
                    end
                end
            end
            tcts_pkg::ST_WAIT_OUT: begin
                if (!r_pend) n_state = tcts_pkg::ST_IDLE;
            end
            default: n_state = tcts_pkg::ST_IDLE;
        endcase
        // a result pushed at the item end is the last one
        push_item.last     = fin;
        push_item.all_idle = r_fidle;
    end

    // held result leaves for the output register
    logic move;
    tcts_pkg::t_out_item hold_out;
    assign move = r_pend && out_free && (push || fin || r_state == tcts_pkg::ST_WAIT_OUT);
    always_comb begin
        hold_out = r_hold;
        if (fin && !push) hold_out.last = 1'b1;
    end

    // sequencer registers and channel update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcts_pkg::ST_IDLE;
            r_play  <= '0;
            r_oval  <= 1'b0;
            r_pend  <= 1'b0;
            r_ch    <= tcts_pkg::CH_RIGHT;
            r_fidle <= 1'b1;
            for (int c = 0; c < 3; c++) begin
                r_ptr[c] <= '0;
                r_len[c] <= '0;
                r_cnt[c] <= '0;
                r_dly[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_in    <= i_item;
                r_ch    <= tcts_pkg::CH_RIGHT;
                r_fidle <= (i_item.op == tcts_pkg::OP_STOP) ? 1'b1 : ~|run_next;
            end
            if (r_state == tcts_pkg::ST_START_WR) begin
                r_len[r_ch]  <= (ram_rdata[15:0] > 16'(NPC)) ? PW'(NPC) : PW'(ram_rdata[15:0]);
                r_ptr[r_ch]  <= PW'(1);
                r_cnt[r_ch]  <= CW'(1);
                r_play[r_ch] <= 1'b1;
                r_ch         <= r_ch + 2'd1;
            end
            if (r_state == tcts_pkg::ST_FETCH) begin
                r_dly[r_ch] <= ram_rdata[31:16];
                r_dly_f     <= ram_rdata[15:0];
            end
            // count bookkeeping for a playing channel in range
            if ((r_state == tcts_pkg::ST_CH && n_state != tcts_pkg::ST_FETCH
                 && (!r_pend || out_free)) || r_state == tcts_pkg::ST_EMIT
                 && (!r_pend || out_free)) begin
                if (r_in.op == tcts_pkg::OP_STOP) begin
                    r_play[r_ch] <= 1'b0;
                end else if (r_play[r_ch]) begin
                    if (r_ptr[r_ch] >= r_len[r_ch]) begin
                        r_play[r_ch] <= 1'b0;
                    end else if (r_state == tcts_pkg::ST_CH && !gap_hit
                                 && cur_cnt == CW'(cur_dly)) begin
                        r_ptr[r_ch] <= r_ptr[r_ch] + PW'(1);
                        r_cnt[r_ch] <= CW'(1);
                    end else if (cur_cnt != tcts_pkg::CNT_MAX) begin
                        r_cnt[r_ch] <= cur_cnt + CW'(1);
                    end
                end
                if (r_ch != tcts_pkg::CH_CENTER) r_ch <= r_ch + 2'd1;
            end
            // hold slot: a result waits until the next one or the item end
            if (move) begin
                r_out <= hold_out;
            end
            if (move) begin
                r_oval <= 1'b1;
            end else if (i_ready) begin
                r_oval <= 1'b0;
            end
            if (push) begin
                r_hold <= push_item;
                r_pend <= 1'b1;
            end else if (move) begin
                r_pend <= 1'b0;
            end
        end
    end

    assign o_valid = r_oval;
    assign o_item  = r_out;

    // assertions
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_item.op != tcts_pkg::OP_LOAD |=> !o_ready)
        else $error("item accepted while busy");
    a_div_only_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> r_state == tcts_pkg::ST_FETCH) else $error("stray divide");
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oval && !i_ready |=> r_oval) else $error("result dropped");
endmodule
`default_nettype wire
